>>> hw/rtl/snmg_pkg.sv
// ----------------------------------------------------------------------------
// snmg_pkg
// Shared types, constants and gradient helpers of the sobel normal map block.
// ----------------------------------------------------------------------------
package snmg_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int QUEUE_DEPTH    = 4;
  localparam int LUM_W          = 16;
  localparam int GRAD_W         = 20;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_Z      = 2'd2;

  localparam logic [11:0] RESET_WIDTH  = 12'd256;
  localparam logic [11:0] RESET_HEIGHT = 12'd256;
  localparam logic [19:0] RESET_Z      = 20'd65536;

  localparam logic [7:0]  LUM_R = 8'd54;
  localparam logic [7:0]  LUM_G = 8'd183;
  localparam logic [7:0]  LUM_B = 8'd19;
  localparam logic [15:0] LEVEL_SCALE = 16'd65025;

  typedef logic [8:0][LUM_W-1:0] win_t;

  typedef struct packed {
    logic [LUM_W-1:0] t;
    logic [LUM_W-1:0] m;
    logic [LUM_W-1:0] b;
  } col_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     flast;
  } job_t;

  typedef enum logic {F_IDLE, F_STEP} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SQX, B_SQY, B_SQZ, B_SUM, B_RLO, B_RHI, B_RFIN,
    B_QSQ, B_QLO, B_QHI, B_QCMP, B_OUT
  } back_state_t;

  function automatic col_t get_col(win_t w, logic [1:0] c);
    col_t r;
    case (c)
      2'd0: begin
        r = '{t: w[0], m: w[3], b: w[6]};
      end
      2'd1: begin
        r = '{t: w[1], m: w[4], b: w[7]};
      end
      default: begin
        r = '{t: w[2], m: w[5], b: w[8]};
      end
    endcase
    return r;
  endfunction

  function automatic logic [GRAD_W-1:0] tap3(logic [LUM_W-1:0] a, logic [LUM_W-1:0] m,
                                             logic [LUM_W-1:0] c);
    return {4'b0, a} + {3'b0, m, 1'b0} + {4'b0, c};
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad_x(col_t l, col_t r);
    return $signed(tap3(r.t, r.m, r.b)) - $signed(tap3(l.t, l.m, l.b));
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad_y(col_t l, col_t c, col_t r);
    return $signed(tap3(l.b, c.b, r.b)) - $signed(tap3(l.t, c.t, r.t));
  endfunction

endpackage

>>> hw/rtl/snmg_front.sv
// ----------------------------------------------------------------------------
// snmg_front
// Takes pixel and drain items, keeps line stores and the 3x3 window, and
// queues a gradient job for every result that a stream position releases.
// ----------------------------------------------------------------------------
module snmg_front #(
  parameter int MAX_WIDTH  = snmg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = snmg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      h_eff,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [23:0]                          s_tdata,   // red, green, blue
  input  logic                                 s_tuser,   // cmd
  input  logic                                 q_full,
  output logic                                 push,
  output snmg_pkg::job_t                       push_job
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = XW + 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 2);
  localparam int LW = snmg_pkg::LUM_W;

  snmg_pkg::front_state_t state, state_next;

  logic [XW-1:0] x, x_next;
  logic [YW-1:0] y, y_next;
  logic [LW-1:0] lum_r;
  logic          drain_r;
  snmg_pkg::win_t win, nwin;

  logic [LW-1:0] mem_up  [MAX_WIDTH];
  logic [LW-1:0] mem_mid [MAX_WIDTH];
  logic [LW-1:0] rd_up, rd_mid;
  logic [XW-1:0] rd_addr;
  logic          wr_en;

  logic          accept, pixel_in, frame_done;
  logic [LW-1:0] lum;
  logic          y_ge2, y_gt_h, y_lt_h, e1, e2, flast1, wrap, cont;
  logic [1:0]    cl1, cl2;
  logic [LW-1:0] top, bot;
  snmg_pkg::job_t job1, job2;

  assign pixel_in   = (s_tuser == snmg_pkg::CMD_PIXEL);
  assign frame_done = (y >= YW'(h_eff));
  assign accept     = s_tvalid && s_tready;
  assign lum = LW'({8'b0, s_tdata[7:0]} * {8'b0, snmg_pkg::LUM_R})
             + LW'({8'b0, s_tdata[15:8]} * {8'b0, snmg_pkg::LUM_G})
             + LW'({8'b0, s_tdata[23:16]} * {8'b0, snmg_pkg::LUM_B});

  always_comb begin
    y_ge2  = (y >= YW'(2));
    y_gt_h = (y > YW'(h_eff));
    y_lt_h = (y < YW'(h_eff));
    e1     = (x == '0) && y_ge2;
    flast1 = (y == YW'(h_eff) + YW'(1));
    cl1    = (w_eff == WW'(1)) ? 2'd2 : 2'd1;
    cl2    = (x == XW'(1)) ? 2'd1 : 2'd0;
    top    = y_ge2 ? rd_up : rd_mid;
    bot    = y_lt_h ? lum_r : rd_mid;
    nwin    = win;
    nwin[0] = win[1];
    nwin[1] = win[2];
    nwin[2] = top;
    nwin[3] = win[4];
    nwin[4] = win[5];
    nwin[5] = rd_mid;
    nwin[6] = win[7];
    nwin[7] = win[8];
    nwin[8] = bot;
    e2   = !y_gt_h && (x != '0) && (y != '0);
    wrap = (({1'b0, x} + CW'(1)) >= CW'(w_eff));
    if (y_gt_h) begin
      x_next = '0;
      y_next = '0;
    end else if (wrap) begin
      x_next = '0;
      y_next = y + YW'(1);
    end else begin
      x_next = x + XW'(1);
      y_next = y;
    end
    job1.gx    = snmg_pkg::grad_x(snmg_pkg::get_col(win, cl1), snmg_pkg::get_col(win, 2'd2));
    job1.gy    = snmg_pkg::grad_y(snmg_pkg::get_col(win, cl1), snmg_pkg::get_col(win, 2'd2),
                                  snmg_pkg::get_col(win, 2'd2));
    job1.flast = flast1;
    job2.gx    = snmg_pkg::grad_x(snmg_pkg::get_col(nwin, cl2), snmg_pkg::get_col(nwin, 2'd2));
    job2.gy    = snmg_pkg::grad_y(snmg_pkg::get_col(nwin, cl2), snmg_pkg::get_col(nwin, 2'd1),
                                  snmg_pkg::get_col(nwin, 2'd2));
    job2.flast = 1'b0;
    push     = (state == snmg_pkg::F_STEP) && (e1 || e2);
    push_job = e1 ? job1 : job2;
    cont     = drain_r && !(e1 || e2) && (y_next >= YW'(h_eff));
    wr_en    = (state == snmg_pkg::F_STEP) && y_lt_h;
    if (state == snmg_pkg::F_IDLE) begin
      rd_addr = (pixel_in && frame_done) ? '0 : x;
    end else begin
      rd_addr = x_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      snmg_pkg::F_IDLE: begin
        if (accept && (pixel_in || frame_done)) state_next = snmg_pkg::F_STEP;
      end
      snmg_pkg::F_STEP: begin
        state_next = cont ? snmg_pkg::F_STEP : snmg_pkg::F_IDLE;
      end
      default: begin
        state_next = snmg_pkg::F_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    case (state)
      snmg_pkg::F_IDLE: s_tready = !q_full;
      default:          s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_up[x]  <= rd_mid;
      mem_mid[x] <= lum_r;
    end
    rd_up  <= mem_up[rd_addr];
    rd_mid <= mem_mid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= snmg_pkg::F_IDLE;
      x       <= '0;
      y       <= '0;
      win     <= '0;
      drain_r <= 1'b0;
    end else begin
      state <= state_next;
      if (restart) begin
        x <= '0;
        y <= '0;
      end else if (state == snmg_pkg::F_IDLE) begin
        if (accept) begin
          lum_r   <= lum;
          drain_r <= !pixel_in;
          if (pixel_in && frame_done) begin
            x <= '0;
            y <= '0;
          end
        end
      end else begin
        if (!y_gt_h) win <= nwin;
        x <= x_next;
        y <= y_next;
      end
    end
  end

endmodule

>>> hw/rtl/snmg_queue.sv
// ----------------------------------------------------------------------------
// snmg_queue
// Short job queue between the window front and the normalizing back.
// ----------------------------------------------------------------------------
module snmg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  snmg_pkg::job_t push_job,
  input  logic           pop,
  output snmg_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  localparam int D  = snmg_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);
  localparam int NW = $clog2(D + 1);

  snmg_pkg::job_t slots [D];
  logic [PW-1:0]  wp, rp;
  logic [NW-1:0]  count;

  assign full  = (count == NW'(D));
  assign empty = (count == '0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == PW'(D - 1)) ? '0 : wp + PW'(1);
      if (pop)  rp <= (rp == PW'(D - 1)) ? '0 : rp + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= NW'(D))
    else $error("queue count beyond depth");

endmodule

>>> hw/rtl/snmg_back.sv
// ----------------------------------------------------------------------------
// snmg_back
// Normalizes a gradient job and maps each component to a byte by an exact
// binary search on one shared multiplier; holds the result item register.
// ----------------------------------------------------------------------------
module snmg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [19:0]    z_eff,
  input  logic           empty,
  input  snmg_pkg::job_t head,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata,   // normal_x, normal_y, normal_z
  output logic           m_tlast    // frame_last
);

  localparam int GW = snmg_pkg::GRAD_W;

  snmg_pkg::back_state_t state, state_next;

  logic signed [GW-1:0] gx_r, gy_r;
  logic        flast_r;
  logic [39:0] v2 [3];
  logic [41:0] s_r, acc, prod;
  logic [57:0] rhs, lhs;
  logic [15:0] aa2;
  logic [7:0]  lo, hi, res_x, res_y, res_z;
  logic [1:0]  comp;
  logic [20:0] op_a, op_b;

  logic [GW-1:0] gx_mag, gy_mag;
  logic [39:0]   v2_sel;
  logic [8:0]    mid_sum;
  logic [7:0]    mid, aa, lo_new, hi_new;
  logic signed [9:0] lvl, lvl_abs;
  logic          v_neg, fits, done, out_free;

  always_comb begin
    gx_mag  = gx_r[GW-1] ? GW'(-gx_r) : gx_r;
    gy_mag  = gy_r[GW-1] ? GW'(-gy_r) : gy_r;
    case (comp)
      2'd0:    v2_sel = v2[0];
      2'd1:    v2_sel = v2[1];
      default: v2_sel = v2[2];
    endcase
    case (comp)
      2'd0:    v_neg = gx_r[GW-1];
      2'd1:    v_neg = gy_r[GW-1];
      default: v_neg = 1'b0;
    endcase
    mid_sum = {1'b0, lo} + {1'b0, hi} + 9'd1;
    mid     = mid_sum[8:1];
    lvl     = $signed({1'b0, mid, 1'b0}) - 10'sd255;
    lvl_abs = lvl[9] ? -lvl : lvl;
    aa      = lvl_abs[7:0];
    lhs     = {16'b0, acc} + {prod[36:0], 21'b0};
    if (lvl[9]) fits = !v_neg || (lhs >= rhs);
    else        fits = !v_neg && (lhs <= rhs);
    lo_new   = fits ? mid : lo;
    hi_new   = fits ? hi : mid - 8'd1;
    done     = (lo_new == hi_new);
    out_free = !m_tvalid || m_tready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      snmg_pkg::B_IDLE: if (!empty) state_next = snmg_pkg::B_SQX;
      snmg_pkg::B_SQX:  state_next = snmg_pkg::B_SQY;
      snmg_pkg::B_SQY:  state_next = snmg_pkg::B_SQZ;
      snmg_pkg::B_SQZ:  state_next = snmg_pkg::B_SUM;
      snmg_pkg::B_SUM:  state_next = snmg_pkg::B_RLO;
      snmg_pkg::B_RLO:  state_next = snmg_pkg::B_RHI;
      snmg_pkg::B_RHI:  state_next = snmg_pkg::B_RFIN;
      snmg_pkg::B_RFIN: state_next = snmg_pkg::B_QSQ;
      snmg_pkg::B_QSQ:  state_next = snmg_pkg::B_QLO;
      snmg_pkg::B_QLO:  state_next = snmg_pkg::B_QHI;
      snmg_pkg::B_QHI:  state_next = snmg_pkg::B_QCMP;
      snmg_pkg::B_QCMP: begin
        if (!done)              state_next = snmg_pkg::B_QSQ;
        else if (comp == 2'd2)  state_next = snmg_pkg::B_OUT;
        else                    state_next = snmg_pkg::B_RLO;
      end
      snmg_pkg::B_OUT:  if (out_free) state_next = snmg_pkg::B_IDLE;
      default:          state_next = snmg_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop  = 1'b0;
    op_a = '0;
    op_b = '0;
    case (state)
      snmg_pkg::B_IDLE: pop = !empty;
      snmg_pkg::B_SQX: begin
        op_a = 21'(gx_mag);
        op_b = 21'(gx_mag);
      end
      snmg_pkg::B_SQY: begin
        op_a = 21'(gy_mag);
        op_b = 21'(gy_mag);
      end
      snmg_pkg::B_SQZ: begin
        op_a = {1'b0, z_eff};
        op_b = {1'b0, z_eff};
      end
      snmg_pkg::B_RLO: begin
        op_a = 21'(snmg_pkg::LEVEL_SCALE);
        op_b = {1'b0, v2_sel[19:0]};
      end
      snmg_pkg::B_RHI: begin
        op_a = 21'(snmg_pkg::LEVEL_SCALE);
        op_b = {1'b0, v2_sel[39:20]};
      end
      snmg_pkg::B_QSQ: begin
        op_a = 21'(aa);
        op_b = 21'(aa);
      end
      snmg_pkg::B_QLO: begin
        op_a = 21'(prod[15:0]);
        op_b = s_r[20:0];
      end
      snmg_pkg::B_QHI: begin
        op_a = 21'(aa2);
        op_b = s_r[41:21];
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {21'b0, op_a} * {21'b0, op_b};
    case (state)
      snmg_pkg::B_IDLE: begin
        gx_r    <= head.gx;
        gy_r    <= head.gy;
        flast_r <= head.flast;
        comp    <= 2'd0;
      end
      snmg_pkg::B_SQY: v2[0] <= prod[39:0];
      snmg_pkg::B_SQZ: v2[1] <= prod[39:0];
      snmg_pkg::B_SUM: begin
        v2[2] <= prod[39:0];
        s_r   <= {2'b0, v2[0]} + {2'b0, v2[1]} + {2'b0, prod[39:0]};
      end
      snmg_pkg::B_RHI: acc <= prod;
      snmg_pkg::B_RFIN: begin
        rhs <= {16'b0, acc} + {prod[37:0], 20'b0};
        lo  <= 8'd0;
        hi  <= 8'd255;
      end
      snmg_pkg::B_QLO: aa2 <= prod[15:0];
      snmg_pkg::B_QHI: acc <= prod;
      snmg_pkg::B_QCMP: begin
        lo <= lo_new;
        hi <= hi_new;
        if (done) begin
          case (comp)
            2'd0:    res_x <= lo_new;
            2'd1:    res_y <= lo_new;
            default: res_z <= lo_new;
          endcase
          comp <= comp + 2'd1;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
    if (state == snmg_pkg::B_OUT && out_free) begin
      m_tdata <= {res_z, res_y, res_x};
      m_tlast <= flast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= snmg_pkg::B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == snmg_pkg::B_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready)                         m_tvalid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/sobel_normal_map_generator.sv
// flow: a pixel step passes the front through its idle and step states; a
// queued result passes the back through its single shared 21x21 multiplier
// (three squares, then per component a scale pass and 8 search steps)
// the back takes one job at a time; the front stalls while the queue is full
// reset: synchronous; registers to defaults, frame position to the start
// ----------------------------------------------------------------------------
// sobel_normal_map_generator
// Sobel normal map from the luminance of a raster RGB pixel stream, with a
// register port for frame size and normal z.
// ----------------------------------------------------------------------------
module sobel_normal_map_generator #(
  parameter int MAX_WIDTH  = snmg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = snmg_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red, green, blue
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // normal_x, normal_y, normal_z
  output logic        m_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [11:0] width_r, height_r;
  logic [19:0] z_r, z_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [1:0]  idx;
  logic        wr, restart;

  logic           push, pop, q_full, q_empty;
  snmg_pkg::job_t push_job, head;

  assign pready  = 1'b1;
  assign idx     = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;
  assign restart = wr && (idx == snmg_pkg::REG_WIDTH || idx == snmg_pkg::REG_HEIGHT);

  always_comb begin
    if (width_r == '0)                  w_eff = WW'(1);
    else if (32'(width_r) > MAX_WIDTH)  w_eff = WW'(MAX_WIDTH);
    else                                w_eff = WW'(width_r);
    if (height_r == '0)                 h_eff = HW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                                h_eff = HW'(height_r);
    z_eff = (z_r == '0) ? 20'd1 : z_r;
    case (idx)
      snmg_pkg::REG_WIDTH:  prdata = {20'b0, width_r};
      snmg_pkg::REG_HEIGHT: prdata = {20'b0, height_r};
      snmg_pkg::REG_Z:      prdata = {12'b0, z_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= snmg_pkg::RESET_WIDTH;
      height_r <= snmg_pkg::RESET_HEIGHT;
      z_r      <= snmg_pkg::RESET_Z;
    end else if (wr) begin
      case (idx)
        snmg_pkg::REG_WIDTH:  width_r  <= pwdata[11:0];
        snmg_pkg::REG_HEIGHT: height_r <= pwdata[11:0];
        snmg_pkg::REG_Z:      z_r      <= pwdata[19:0];
        default:              z_r      <= z_r;
      endcase
    end
  end

  snmg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  snmg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  snmg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .z_eff    (z_eff),
    .empty    (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sobel_normal_map_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_normal_map_generator_tb
// Self-checking bench: drives pixel and drain items over the stream port and
// the frame size and normal z over the register port, predicts every normal
// from luminance, sobel gradients and exact byte quantization, and compares
// each output item in order under random idling and back-pressure.
// ----------------------------------------------------------------------------
module sobel_normal_map_generator_tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 200;

  typedef struct packed {
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] nz;
    logic       last;
  } normal_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // red, green, blue
  logic        s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // normal_x, normal_y, normal_z
  logic        m_tlast;   // frame_last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sobel_normal_map_generator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [11:0] cfg_width, cfg_height;
  logic [19:0] cfg_z;
  logic [15:0] upper_lum [snmg_pkg::DEF_MAX_WIDTH];
  logic [15:0] middle_lum [snmg_pkg::DEF_MAX_WIDTH];
  logic [15:0] lum_win [9];
  int unsigned col_in, row_in;

  normal_t expected_normals [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  int items_sent = 0;

  function automatic int unsigned eff_width();
    if (cfg_width < 1) return 1;
    if (cfg_width > snmg_pkg::DEF_MAX_WIDTH) return snmg_pkg::DEF_MAX_WIDTH;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height < 1) return 1;
    if (cfg_height > snmg_pkg::DEF_MAX_HEIGHT) return snmg_pkg::DEF_MAX_HEIGHT;
    return cfg_height;
  endfunction

  function automatic bit level_fits(int q, longint v, longint unsigned s);
    longint a;
    longint unsigned aa, av, lhs, rhs;
    a = 2 * q - 255;
    aa = a < 0 ? -a : a;
    av = v < 0 ? -v : v;
    lhs = aa * aa * s;
    rhs = 64'd65025 * av * av;
    if (a < 0) return (v >= 0) ? 1'b1 : (lhs >= rhs);
    if (v < 0) return 1'b0;
    return lhs <= rhs;
  endfunction

  function automatic logic [7:0] to_byte(longint v, longint unsigned s);
    int lo, hi, mid;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (level_fits(mid, v, s)) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  function automatic normal_t normal_of(int cl, int cc, int cr, int unsigned ox,
                                        int unsigned oy, int unsigned w, int unsigned h);
    longint gx, gy, zz;
    longint unsigned s;
    normal_t n;
    gx = (longint'(lum_win[cr]) + 2 * lum_win[3 + cr] + lum_win[6 + cr])
       - (longint'(lum_win[cl]) + 2 * lum_win[3 + cl] + lum_win[6 + cl]);
    gy = (longint'(lum_win[6 + cl]) + 2 * lum_win[6 + cc] + lum_win[6 + cr])
       - (longint'(lum_win[cl]) + 2 * lum_win[cc] + lum_win[cr]);
    zz = (cfg_z == 0) ? 1 : cfg_z;
    s = gx * gx + gy * gy + zz * zz;
    n.nx = to_byte(gx, s);
    n.ny = to_byte(gy, s);
    n.nz = to_byte(zz, s);
    n.last = (ox == w - 1 && oy == h - 1);
    return n;
  endfunction

  function automatic void step_position(logic [15:0] lum, output bit got, output normal_t n);
    int unsigned w, h, x, y;
    logic [15:0] top, mid, bot;
    w = eff_width();
    h = eff_height();
    x = col_in;
    y = row_in;
    got = 0;
    if (x == 0 && y >= 2) begin
      n = normal_of(w == 1 ? 2 : 1, 2, 2, w - 1, y - 2, w, h);
      got = 1;
    end
    if (y > h) begin
      col_in = 0;
      row_in = 0;
      return;
    end
    mid = middle_lum[x];
    top = y >= 2 ? upper_lum[x] : mid;
    bot = mid;
    if (y < h) begin
      bot = lum;
      upper_lum[x] = mid;
      middle_lum[x] = lum;
    end
    for (int r = 0; r < 3; r++) begin
      lum_win[r * 3] = lum_win[r * 3 + 1];
      lum_win[r * 3 + 1] = lum_win[r * 3 + 2];
    end
    lum_win[2] = top;
    lum_win[5] = mid;
    lum_win[8] = bot;
    if (x >= 1 && y >= 1) begin
      n = normal_of(x == 1 ? 1 : 0, 1, 2, x - 1, y - 1, w, h);
      got = 1;
    end
    if (x + 1 >= w) begin
      col_in = 0;
      row_in = y + 1;
    end else begin
      col_in = x + 1;
    end
  endfunction

  function automatic void predict_normal(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    bit got;
    normal_t n;
    int unsigned h;
    h = eff_height();
    got = 0;
    if (cmd == snmg_pkg::CMD_PIXEL) begin
      if (row_in >= h) begin
        col_in = 0;
        row_in = 0;
      end
      step_position(16'(54 * r + 183 * g + 19 * b), got, n);
    end else begin
      while (row_in >= h && !got) step_position(16'd0, got, n);
    end
    if (got) expected_normals.push_back(n);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // output checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_normals.size() == 0) begin
        report_mismatch($sformatf("unexpected item %h last %b", m_tdata, m_tlast));
      end else begin
        normal_t e;
        e = expected_normals.pop_front();
        if (m_tdata[7:0] !== e.nx)
          report_mismatch($sformatf("normal_x %0d want %0d", m_tdata[7:0], e.nx));
        if (m_tdata[15:8] !== e.ny)
          report_mismatch($sformatf("normal_y %0d want %0d", m_tdata[15:8], e.ny));
        if (m_tdata[23:16] !== e.nz)
          report_mismatch($sformatf("normal_z %0d want %0d", m_tdata[23:16], e.nz));
        if (m_tlast !== e.last)
          report_mismatch($sformatf("frame_last %b want %b", m_tlast, e.last));
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {b, g, r};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_normal(cmd, r, g, b);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      snmg_pkg::REG_WIDTH: begin
        cfg_width = value[11:0];
        col_in = 0;
        row_in = 0;
      end
      snmg_pkg::REG_HEIGHT: begin
        cfg_height = value[11:0];
        col_in = 0;
        row_in = 0;
      end
      default: begin
        cfg_z = value[19:0];
      end
    endcase
  endtask

  task automatic set_frame(int w, int h, int z);
    wait_idle();
    write_reg(snmg_pkg::REG_WIDTH, w);
    write_reg(snmg_pkg::REG_HEIGHT, h);
    write_reg(snmg_pkg::REG_Z, z);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel();
    send_item(snmg_pkg::CMD_PIXEL, rand_channel(), rand_channel(), rand_channel());
  endtask

  task automatic send_drain();
    send_item(snmg_pkg::CMD_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  task automatic run_frame(int w, int h, int extra);
    for (int i = 0; i < w * h; i++) send_pixel();
    for (int i = 0; i < w + 1 + extra; i++) send_drain();
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 300; i++) send_pixel();
  endtask

  task automatic test_directed();
    logic [7:0] px [8][3];
    px = '{'{0, 0, 0}, '{255, 255, 255}, '{255, 0, 0}, '{0, 255, 0},
           '{0, 0, 255}, '{255, 255, 255}, '{0, 0, 0}, '{128, 64, 32}};
    set_frame(3, 3, 1);
    send_drain();                                   // drain with nothing pending
    for (int i = 0; i < 9; i++)
      send_item(snmg_pkg::CMD_PIXEL, px[i % 8][0], px[i % 8][1], px[i % 8][2]);
    for (int i = 0; i < 5; i++) send_drain();       // one more than pending
    set_frame(1, 1, 20'hfffff);
    send_item(snmg_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255);
    send_drain();
    send_drain();
    set_frame(2, 2, 0);
    for (int i = 0; i < 4; i++)
      send_item(snmg_pkg::CMD_PIXEL, px[i + 1][0], px[i + 1][1], px[i + 1][2]);
    send_drain();
    send_item(snmg_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd0); // abandons the rest of the frame
    send_drain();                                   // incomplete frame, no result
  endtask

  task automatic test_extreme_sizes();
    set_frame(0, 3, 65536);                         // zero width runs as one column
    run_frame(1, 3, 0);
    set_frame(5, 0, 20'h00400);                     // zero height runs as one row
    run_frame(5, 1, 1);
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    int start, w, h, mode, z, k;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      z = ($urandom_range(3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 20'hfffff);
      set_frame(w, h, z);
      mode = $urandom_range(9);
      if (mode == 0) begin
        k = $urandom_range(w * h);
        for (int i = 0; i < k; i++) send_pixel();
        repeat ($urandom_range(1, 3)) send_drain();
      end else if (mode == 1) begin
        for (int i = 0; i < w * h; i++) send_pixel();
        repeat ($urandom_range(w)) send_drain();
        for (int i = 0; i < w * h; i++) send_pixel();
        run_frame(0, 0, w);
      end else begin
        run_frame(w, h, $urandom_range(2));
      end
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  task automatic test_backpressure();
    set_frame(16, 4, 30000);
    hold_left = 3000;
    run_frame(16, 4, 0);
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= snmg_pkg::CMD_PIXEL;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_width = snmg_pkg::RESET_WIDTH;
    cfg_height = snmg_pkg::RESET_HEIGHT;
    cfg_z = snmg_pkg::RESET_Z;
    col_in = 0;
    row_in = 0;
    for (int i = 0; i < snmg_pkg::DEF_MAX_WIDTH; i++) begin
      upper_lum[i] = '0;
      middle_lum[i] = '0;
    end
    for (int i = 0; i < 9; i++) lum_win[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random(300, 0, 0);
    test_random(300, 78, 0);
    test_random(300, 0, 78);
    test_random(300, 31, 31);
    test_extreme_sizes();

    wait_idle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
